// File: hdl/isoas_pkg.sv
package isoas_pkg;

   localparam int FRAME_BYTES   = 9;
   localparam int UID_BYTES_DEF = 10;

   localparam logic [7:0]  CASCADE_TAG    = 8'h88;
   localparam logic [7:0]  NVB_FULL       = 8'h70;
   localparam logic [7:0]  SEL_CL1        = 8'h93;
   localparam logic [7:0]  KNOWN_BITS_MAX = 8'd80;
   localparam logic [15:0] CRC_PRESET     = 16'h6363;
   localparam logic [15:0] CRC_POLY       = 16'h8408;
   localparam int          SAK_CASCADE    = 2;

   typedef enum logic [1:0] {
      CMD_UID_LOAD, CMD_START, CMD_RSP_BYTE, CMD_RSP_DONE
   } cmd_type;

   typedef enum logic [1:0] {
      LINK_OK, LINK_COLL, LINK_TIMEOUT, LINK_ERROR
   } link_type;

   typedef enum logic [1:0] {
      KIND_FRAME, KIND_UID, KIND_STATUS
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK, ST_INVALID, ST_COLLISION, ST_INTERNAL, ST_ERROR, ST_CRC, ST_TIMEOUT, ST_NO_ROOM
   } status_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_UID_WR, OP_START_INIT, OP_LVL_HEAD, OP_LVL_TAG, OP_LVL_COPY, OP_LVL_END,
      OP_SEND_HEAD, OP_BCC, OP_CRC, OP_CRC_LO, OP_CRC_HI, OP_EMIT_FRAME, OP_RSP_BYTE,
      OP_COLL, OP_FULL, OP_SEL_INIT, OP_SEL_COPY, OP_CL_INC, OP_SUCC_INIT, OP_EMIT_UID,
      OP_EMIT_FAIL
   } dp_op_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_LVL_HEAD, S_LVL_TAG, S_LVL_COPY, S_SEND_HEAD, S_SEND_BCC,
      S_SEND_CRC, S_SEND_CRCLO, S_SEND_CRCHI, S_EMIT_FRAME, S_DONE, S_SEL_COPY,
      S_SEL_CHECK, S_EMIT_UID, S_FAIL
   } ctrl_state_type;

   typedef struct packed {
      logic       latch;
      dp_op_type  op;
      status_type fail_code;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type  cmd;
      link_type link;
      logic     phase;
      logic     kb_bad;
      logic     full;
      logic     copy_done;
      logic     crc_last;
      logic     emit_last;
      logic     creg_inv;
      logic     no_progress;
      logic     overflow;
      logic     sel_last;
      logic     len_bad;
      logic     crc_bad;
      logic     cascade;
      logic     cl_max;
      logic     uid_last;
      logic     out_free;
   } dp_stat_type;

   // CRC_A over one byte, reflected, eight shifts
   function automatic logic [15:0] crc_a_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: hdl/isoas_dp.sv
module isoas_dp #(
   parameter int UID_BYTES = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  isoas_pkg::dp_cmd_type cmd,
   output isoas_pkg::dp_stat_type stat,
   input  logic [39:0]          req_tdata,
   input  logic [1:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,
   output logic [1:0]           rsp_tuser,
   output logic                 rsp_tlast
);
   import isoas_pkg::*;

   localparam int         UW     = $clog2(UID_BYTES);
   localparam logic [4:0] UidLim = 5'(UID_BYTES);
   localparam logic [3:0] FbLim  = 4'(FRAME_BYTES);

   logic [7:0] frame_ff [FRAME_BYTES];
   logic [7:0] uid_ff [UID_BYTES];

   cmd_type    cmd_ff;
   link_type   link_ff;
   logic [3:0] pos_ff, ks_ff;
   logic [7:0] db_ff, kb_ff, creg_ff;
   logic [2:0] rxb_ff;

   logic [1:0] cl_ff;
   logic [5:0] lkb_ff;
   logic [7:0] tkb_ff;
   logic [3:0] rs_ff, rc_ff, ss_ff;
   logic       phase_ff;
   logic [2:0] flb_ff;
   logic [6:0] lk_ff;
   logic       ct_ff;
   logic [2:0] nbytes_ff;
   logic [3:0] idx_ff, used_ff, cnt_ff;
   logic [15:0] crc_ff;

   logic       rsp_valid_ff, rsp_last_ff;
   kind_type   rsp_kind_ff;
   status_type rsp_st_ff;
   logic [7:0] rsp_byte_ff, rsp_sak_ff;
   logic [2:0] rsp_tb_ff;
   logic [3:0] rsp_len_ff;

   logic       rsp_last_in;
   kind_type   rsp_kind_in;
   status_type rsp_st_in;
   logic [7:0] rsp_byte_in, rsp_sak_in;
   logic [2:0] rsp_tb_in;
   logic [3:0] rsp_len_in;

   logic [1:0] cl_m1;
   logic [3:0] base;
   logic [7:0] sel_code;
   logic       ct;
   logic [8:0] diff;
   logic [6:0] lk;
   logic [7:0] lk_round;
   logic [3:0] bytes_raw, maxb;
   logic [2:0] nbytes;
   logic [7:0] lk_ct;
   logic [5:0] lkb_lvl;
   logic [2:0] tlb;
   logic [3:0] sidx, used;
   logic [7:0] nvb, bcc;
   logic [3:0] room, rsp_at;
   logic       store_ok;
   logic [7:0] mask, merged;
   logic [5:0] p, p_m1;
   logic [3:0] col_ix;
   logic       tag;
   logic [3:0] sel_src, sel_n, succ_len;
   logic [15:0] crc_next, sak_crc;
   logic [3:0] frd_idx, urd_idx, uwa, fwa;
   logic [7:0] frd, urd, fwd, uwd;
   logic       fwe, uwe;

   always_comb begin
      cl_m1    = cl_ff - 2'd1;
      base     = {1'b0, cl_m1, 1'b0} + {2'b00, cl_m1};
      sel_code = SEL_CL1 + {5'd0, cl_m1, 1'b0};
      ct       = (tkb_ff != 8'd0) &&
                 (((cl_ff == 2'd1) && (ss_ff > 4'd4)) || ((cl_ff == 2'd2) && (ss_ff > 4'd7)));
      diff     = {1'b0, tkb_ff} - {2'b00, base, 3'b000};
      lk       = diff[8] ? 7'd0 : diff[6:0];
      lk_round = {1'b0, lk} + 8'd7;
      bytes_raw = lk_round[6:3];
      maxb     = ct ? 4'd3 : 4'd4;
      nbytes   = (bytes_raw > maxb) ? maxb[2:0] : bytes_raw[2:0];
      lk_ct    = {1'b0, lk_ff} + (ct_ff ? 8'd8 : 8'd0);
      lkb_lvl  = (lk_ct > 8'd32) ? 6'd32 : lk_ct[5:0];

      tlb  = lkb_ff[2:0];
      sidx = 4'd2 + {2'b00, lkb_ff[4:3]};
      nvb  = {sidx, 1'b0, tlb};
      used = sidx + {3'b000, (tlb != 3'd0)};
      bcc  = frame_ff[2] ^ frame_ff[3] ^ frame_ff[4] ^ frame_ff[5];

      room     = FbLim - rs_ff;
      rsp_at   = rs_ff + rc_ff;
      store_ok = rc_ff < room;

      p      = (creg_ff[4:0] == 5'd0) ? 6'd32 : {1'b0, creg_ff[4:0]};
      p_m1   = p - 6'd1;
      col_ix = 4'd1 + {1'b0, p[5:3]} + {3'b000, (p[2:0] != 3'd0)};

      tag      = frame_ff[2] == CASCADE_TAG;
      sel_src  = tag ? 4'd3 : 4'd2;
      sel_n    = tag ? 4'd3 : 4'd4;
      succ_len = {1'b0, cl_ff, 1'b0} + {2'b00, cl_ff} + 4'd1;

      case (cmd.op)
         OP_RSP_BYTE: frd_idx = rsp_at;
         OP_COLL:     frd_idx = col_ix;
         OP_SEL_COPY: frd_idx = sel_src + cnt_ff;
         default:     frd_idx = cnt_ff;
      endcase
      frd = (frd_idx < FbLim) ? frame_ff[frd_idx] : 8'h00;

      urd_idx = (cmd.op == OP_LVL_COPY) ? base + cnt_ff : cnt_ff;
      urd = ({1'b0, urd_idx} < UidLim) ? uid_ff[urd_idx[UW-1:0]] : 8'h00;

      // first response byte keeps the sent bits below the split
      mask   = 8'hFF << flb_ff;
      merged = ((rc_ff == 4'd0) && (flb_ff != 3'd0)) ? ((frd & ~mask) | (db_ff & mask)) : db_ff;

      crc_next = crc_a_byte(crc_ff, frd);
      sak_crc  = crc_a_byte(CRC_PRESET, frame_ff[6]);

      fwe = 1'b1;
      fwa = 4'd0;
      fwd = 8'h00;
      case (cmd.op)
         OP_LVL_HEAD: begin fwa = 4'd0; fwd = sel_code; end
         OP_LVL_TAG:  begin fwe = ct_ff; fwa = idx_ff; fwd = CASCADE_TAG; end
         OP_LVL_COPY: begin fwa = idx_ff; fwd = urd; end
         OP_SEND_HEAD: begin fwa = 4'd1; fwd = lkb_ff[5] ? NVB_FULL : nvb; end
         OP_BCC:      begin fwa = 4'd6; fwd = bcc; end
         OP_CRC_LO:   begin fwa = 4'd7; fwd = crc_ff[7:0]; end
         OP_CRC_HI:   begin fwa = 4'd8; fwd = crc_ff[15:8]; end
         OP_RSP_BYTE: begin fwe = store_ok; fwa = rsp_at; fwd = merged; end
         OP_COLL:     begin fwa = col_ix; fwd = frd | (8'd1 << p_m1[2:0]); end
         default:     fwe = 1'b0;
      endcase

      uwa = (cmd.op == OP_UID_WR) ? pos_ff : base + cnt_ff;
      uwd = (cmd.op == OP_UID_WR) ? db_ff : frd;
      uwe = ((cmd.op == OP_UID_WR) || (cmd.op == OP_SEL_COPY)) && ({1'b0, uwa} < UidLim);
   end

   always_comb begin
      stat.cmd         = cmd_ff;
      stat.link        = link_ff;
      stat.phase       = phase_ff;
      stat.kb_bad      = kb_ff > KNOWN_BITS_MAX;
      stat.full        = lkb_ff[5];
      stat.copy_done   = cnt_ff == {1'b0, nbytes_ff};
      stat.crc_last    = cnt_ff == 4'd6;
      stat.emit_last   = cnt_ff == used_ff - 4'd1;
      stat.creg_inv    = creg_ff[5];
      stat.no_progress = p <= lkb_ff;
      stat.overflow    = rc_ff > room;
      stat.sel_last    = cnt_ff == sel_n - 4'd1;
      stat.len_bad     = (rc_ff != 4'd3) || (rxb_ff != 3'd0);
      stat.crc_bad     = (frame_ff[7] != sak_crc[7:0]) || (frame_ff[8] != sak_crc[15:8]);
      stat.cascade     = frame_ff[6][SAK_CASCADE];
      stat.cl_max      = cl_ff == 2'd3;
      stat.uid_last    = cnt_ff == succ_len - 4'd1;
      stat.out_free    = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      rsp_kind_in = KIND_FRAME;
      rsp_byte_in = 8'h00;
      rsp_tb_in   = 3'd0;
      rsp_st_in   = ST_OK;
      rsp_len_in  = 4'd0;
      rsp_sak_in  = 8'h00;
      rsp_last_in = 1'b1;
      case (cmd.op)
         OP_EMIT_FRAME: begin
            rsp_byte_in = frd; rsp_tb_in = flb_ff; rsp_last_in = stat.emit_last;
         end
         OP_EMIT_UID: begin
            rsp_kind_in = KIND_UID; rsp_byte_in = urd; rsp_len_in = succ_len;
            rsp_sak_in = frame_ff[6]; rsp_last_in = stat.uid_last;
         end
         OP_EMIT_FAIL: begin rsp_kind_in = KIND_STATUS; rsp_st_in = cmd.fail_code; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (fwe) frame_ff[fwa] <= fwd;
      if (uwe) uid_ff[uwa[UW-1:0]] <= uwd;
      if (cmd.latch) begin
         cmd_ff  <= cmd_type'(req_tuser);
         pos_ff  <= req_tdata[3:0];
         db_ff   <= req_tdata[11:4];
         kb_ff   <= req_tdata[19:12];
         ks_ff   <= req_tdata[23:20];
         link_ff <= link_type'(req_tdata[25:24]);
         creg_ff <= req_tdata[33:26];
         rxb_ff  <= req_tdata[36:34];
      end
      case (cmd.op)
         OP_LVL_HEAD: begin
            lk_ff <= lk; ct_ff <= ct; nbytes_ff <= nbytes; idx_ff <= 4'd2; cnt_ff <= 4'd0;
         end
         OP_LVL_TAG:  idx_ff <= idx_ff + {3'b000, ct_ff};
         OP_LVL_COPY: begin idx_ff <= idx_ff + 4'd1; cnt_ff <= cnt_ff + 4'd1; end
         OP_SEND_HEAD: begin cnt_ff <= 4'd0; crc_ff <= CRC_PRESET; end
         OP_CRC:      begin crc_ff <= crc_next; cnt_ff <= cnt_ff + 4'd1; end
         OP_CRC_HI, OP_SEL_INIT, OP_SUCC_INIT: cnt_ff <= 4'd0;
         OP_EMIT_FRAME, OP_SEL_COPY, OP_EMIT_UID: cnt_ff <= cnt_ff + 4'd1;
         default: ;
      endcase
      if (!rsp_valid_ff || rsp_tready) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_byte_ff <= rsp_byte_in;
         rsp_tb_ff   <= rsp_tb_in;
         rsp_st_ff   <= rsp_st_in;
         rsp_len_ff  <= rsp_len_in;
         rsp_sak_ff  <= rsp_sak_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cl_ff <= 2'd1; lkb_ff <= 6'd0; tkb_ff <= 8'd0; rs_ff <= 4'd0; rc_ff <= 4'd0;
         phase_ff <= 1'b0; flb_ff <= 3'd0; ss_ff <= 4'd0; used_ff <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (cmd.op)
            OP_START_INIT: begin tkb_ff <= kb_ff; ss_ff <= ks_ff; cl_ff <= 2'd1; end
            OP_LVL_END: lkb_ff <= lkb_lvl;
            OP_SEND_HEAD: begin
               flb_ff  <= lkb_ff[5] ? 3'd0 : tlb;
               used_ff <= lkb_ff[5] ? FbLim : used;
               rs_ff   <= lkb_ff[5] ? 4'd6 : sidx;
               rc_ff   <= 4'd0;
               phase_ff <= 1'b1;
            end
            OP_RSP_BYTE: if (rc_ff != 4'd15) rc_ff <= rc_ff + 4'd1;
            OP_COLL: lkb_ff <= p;
            OP_FULL: lkb_ff <= 6'd32;
            OP_CL_INC: cl_ff <= cl_ff + 2'd1;
            OP_SUCC_INIT, OP_EMIT_FAIL: phase_ff <= 1'b0;
            default: ;
         endcase
         if ((cmd.op == OP_EMIT_FRAME) || (cmd.op == OP_EMIT_UID) || (cmd.op == OP_EMIT_FAIL))
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {3'b000, rsp_sak_ff, rsp_len_ff, rsp_st_ff, rsp_tb_ff, rsp_tb_ff,
                        rsp_byte_ff};

endmodule

// File: hdl/isoas_ctrl.sv
module isoas_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  isoas_pkg::dp_stat_type stat,
   output isoas_pkg::dp_cmd_type  cmd
);
   import isoas_pkg::*;

   ctrl_state_type state_ff, state_in;
   status_type     fail_ff, fail_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fail_ff  <= ST_OK;
      end else begin
         state_ff <= state_in;
         fail_ff  <= fail_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      fail_in       = fail_ff;
      cmd.op        = OP_NONE;
      cmd.fail_code = fail_ff;
      req_tready    = state_ff == S_IDLE;
      cmd.latch     = req_tvalid && (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_DECODE;
         S_DECODE: begin
            state_in = S_IDLE;
            case (stat.cmd)
               CMD_UID_LOAD: cmd.op = OP_UID_WR;
               CMD_START: begin
                  if (stat.kb_bad) begin
                     fail_in = ST_INVALID; state_in = S_FAIL;
                  end else begin
                     cmd.op = OP_START_INIT; state_in = S_LVL_HEAD;
                  end
               end
               CMD_RSP_BYTE: if (stat.phase) cmd.op = OP_RSP_BYTE;
               default: if (stat.phase) state_in = S_DONE;
            endcase
         end
         S_LVL_HEAD: begin cmd.op = OP_LVL_HEAD; state_in = S_LVL_TAG; end
         S_LVL_TAG:  begin cmd.op = OP_LVL_TAG; state_in = S_LVL_COPY; end
         S_LVL_COPY: begin
            if (stat.copy_done) begin
               cmd.op = OP_LVL_END; state_in = S_SEND_HEAD;
            end else begin
               cmd.op = OP_LVL_COPY;
            end
         end
         S_SEND_HEAD: begin
            cmd.op = OP_SEND_HEAD;
            state_in = stat.full ? S_SEND_BCC : S_EMIT_FRAME;
         end
         S_SEND_BCC: begin cmd.op = OP_BCC; state_in = S_SEND_CRC; end
         S_SEND_CRC: begin
            cmd.op = OP_CRC;
            if (stat.crc_last) state_in = S_SEND_CRCLO;
         end
         S_SEND_CRCLO: begin cmd.op = OP_CRC_LO; state_in = S_SEND_CRCHI; end
         S_SEND_CRCHI: begin cmd.op = OP_CRC_HI; state_in = S_EMIT_FRAME; end
         S_EMIT_FRAME: if (stat.out_free) begin
            cmd.op = OP_EMIT_FRAME;
            if (stat.emit_last) state_in = S_IDLE;
         end
         S_DONE: begin
            state_in = S_FAIL;
            if (stat.link == LINK_TIMEOUT)    fail_in = ST_TIMEOUT;
            else if (stat.link == LINK_ERROR) fail_in = ST_ERROR;
            else if (stat.overflow)           fail_in = ST_NO_ROOM;
            else if (stat.link == LINK_COLL) begin
               if (stat.creg_inv)         fail_in = ST_COLLISION;
               else if (stat.no_progress) fail_in = ST_INTERNAL;
               else begin
                  cmd.op = OP_COLL; state_in = S_SEND_HEAD;
               end
            end else if (!stat.full) begin
               cmd.op = OP_FULL; state_in = S_SEND_HEAD;
            end else begin
               cmd.op = OP_SEL_INIT; state_in = S_SEL_COPY;
            end
         end
         S_SEL_COPY: begin
            cmd.op = OP_SEL_COPY;
            if (stat.sel_last) state_in = S_SEL_CHECK;
         end
         S_SEL_CHECK: begin
            state_in = S_FAIL;
            if (stat.len_bad)      fail_in = ST_ERROR;
            else if (stat.crc_bad) fail_in = ST_CRC;
            else if (stat.cascade) begin
               if (stat.cl_max) fail_in = ST_INTERNAL;
               else begin
                  cmd.op = OP_CL_INC; state_in = S_LVL_HEAD;
               end
            end else begin
               cmd.op = OP_SUCC_INIT; state_in = S_EMIT_UID;
            end
         end
         S_EMIT_UID: if (stat.out_free) begin
            cmd.op = OP_EMIT_UID;
            if (stat.uid_last) state_in = S_IDLE;
         end
         S_FAIL: if (stat.out_free) begin
            cmd.op = OP_EMIT_FAIL; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// File: hdl/iso14443a_anticollision_select_top.sv
// Type A anticollision and SELECT sequencer, reader side, cascade levels 1 to 3.
// Request channel (req_): tuser carries the command (load uid byte, start,
// response byte, response done); tdata the fields listed at the port.
// Result channel (rsp_): tuser is the result kind, tlast marks the last result
// a request causes; frame bytes to send, uid bytes on success, or one status.
// One request at a time: req_tready is high only when the sequencer is idle.
// Load and response-byte requests are taken with no result. A start or response-done
// that emits a frame first does its set-up (uid copy, BCC and a byte-wide CRC_A over
// 7 bytes, as the case needs), then emits one byte per cycle while the receiver is
// ready; success reports one uid byte per cycle on the same terms.
// A result sits in an output register, so the last one may wait while the next
// request is taken; while the receiver stalls, emission simply pauses.
// Reset: idle, cascade level 1, bit and response counters cleared; uid and frame
// stores and the loop counters hold whatever was last written.
module iso14443a_anticollision_select_top #(
   parameter int UID_BYTES = isoas_pkg::UID_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // uid_position, data_byte, known_bits, known_uid_size, link_status,
   // collision_register, rx_valid_bits, zero pad
   input  logic [39:0] req_tdata,
   // command
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // byte_value, tx_last_bits, rx_align, status, uid_length, select_ack, zero pad
   output logic [31:0] rsp_tdata,
   // kind
   output logic [1:0]  rsp_tuser,
   // last_of_run
   output logic        rsp_tlast
);
   import isoas_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   isoas_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   isoas_dp #(.UID_BYTES(UID_BYTES)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
